### rtl/nmt_pkg.sv
// Shared codes for the controlled-node network-management state machine:
// node state codes, event codes and the step result type.
// No dependencies.
package nmt_pkg;

    // node state codes
    localparam logic [3:0] ST_OFFLINE    = 4'd0;
    localparam logic [3:0] ST_INIT       = 4'd1;
    localparam logic [3:0] ST_RST_APP    = 4'd2;
    localparam logic [3:0] ST_RST_COM    = 4'd3;
    localparam logic [3:0] ST_RST_CFG    = 4'd4;
    localparam logic [3:0] ST_NOT_ACTIVE = 4'd5;
    localparam logic [3:0] ST_BASIC_ETH  = 4'd6;
    localparam logic [3:0] ST_PREOP1     = 4'd7;
    localparam logic [3:0] ST_PREOP2     = 4'd8;
    localparam logic [3:0] ST_READY      = 4'd9;
    localparam logic [3:0] ST_OPER       = 4'd10;
    localparam logic [3:0] ST_STOPPED    = 4'd11;

    // event codes
    localparam logic [4:0] EV_SW_RESET     = 5'd0;
    localparam logic [4:0] EV_START_UP     = 5'd1;
    localparam logic [4:0] EV_SWITCH_ON    = 5'd3;
    localparam logic [4:0] EV_TO_PREOP1    = 5'd4;
    localparam logic [4:0] EV_TO_PREOP2    = 5'd5;
    localparam logic [4:0] EV_TO_READY     = 5'd6;
    localparam logic [4:0] EV_TO_OPER      = 5'd7;
    localparam logic [4:0] EV_REQ_RST_APP  = 5'd9;
    localparam logic [4:0] EV_REQ_RST_COM  = 5'd10;
    localparam logic [4:0] EV_REQ_RST_CFG  = 5'd11;
    localparam logic [4:0] EV_ENTER_READY  = 5'd12;
    localparam logic [4:0] EV_STOP_NODE    = 5'd13;
    localparam logic [4:0] EV_INT_RST_APP  = 5'd14;
    localparam logic [4:0] EV_INT_RST_COM  = 5'd15;
    localparam logic [4:0] EV_INT_RST_CFG  = 5'd16;
    localparam logic [4:0] EV_RECV_SOC     = 5'd21;
    localparam logic [4:0] EV_RECV_SOA     = 5'd22;
    localparam logic [4:0] EV_ENABLE_READY = 5'd23;
    localparam logic [4:0] EV_START_NODE   = 5'd25;
    localparam logic [4:0] EV_RESYNC       = 5'd26;

    // outcome of one event: new state, status and handshake flags
    typedef struct packed {
        logic [3:0] node_state;
        logic       status;
        logic       mgr_flag;
        logic       app_flag;
    } nmt_result_t;

endpackage

### rtl/nmt_node_state_machine.sv
// Top level of the controlled-node network-management state machine.
// Depends on nmt_pkg and nmt_step.
//
// Usage:
//   Event channel: evt_valid / evt_stall with event_code (5 bits). A
//   transaction completes on a rising edge with evt_valid high and
//   evt_stall low.
//   Result channel: res_valid / res_stall with new_state, status,
//   manager_enabled and application_entered. Exactly one result
//   transaction follows every event transaction, in order.
//   Path: an event is registered in the event stage, processed by the
//   transition logic and its result registered in the result stage, from
//   which it is offered on the result channel.
//   Throughput: one event per cycle while no result is held by res_stall;
//   the node state and flag registers are updated in the same cycle as the
//   result register, so the next event sees the new state without a bubble.
//   Stall: while a result waits under res_stall, the event stage holds and
//   evt_stall rises only once that stage is also full.
//   Reset: rst_n low clears both stages, puts the node in Offline and
//   clears both handshake flags.
module nmt_node_state_machine
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       evt_valid,
    output logic       evt_stall,
    input  logic [4:0] event_code,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [3:0] new_state,
    output logic       status,
    output logic       manager_enabled,
    output logic       application_entered
);

    logic                 evt_valid_reg;
    logic                 evt_valid_next;
    logic [4:0]           evt_code_reg;
    logic [3:0]           node_state_reg;
    logic [3:0]           node_state_next;
    logic                 mgr_flag_reg;
    logic                 mgr_flag_next;
    logic                 app_flag_reg;
    logic                 app_flag_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    nmt_pkg::nmt_result_t res_reg;
    nmt_pkg::nmt_result_t step_res;
    logic                 advance;
    logic                 evt_take;
    logic                 process;

    // transition logic between event stage and result stage
    nmt_step u_step
    (
        .cur_state    (node_state_reg),
        .cur_mgr_flag (mgr_flag_reg),
        .cur_app_flag (app_flag_reg),
        .event_code   (evt_code_reg),
        .result       (step_res)
    );

    // pipeline flow control
    assign advance   = !res_valid_reg || !res_stall;
    assign process   = advance && evt_valid_reg;
    assign evt_stall = evt_valid_reg && !advance;
    assign evt_take  = evt_valid && !evt_stall;

    // next values of control state
    always_comb
    begin
        evt_valid_next  = evt_valid_reg;
        res_valid_next  = res_valid_reg;
        node_state_next = node_state_reg;
        mgr_flag_next   = mgr_flag_reg;
        app_flag_next   = app_flag_reg;
        if (advance)
        begin
            res_valid_next = evt_valid_reg;
        end
        // event stage fills on every taken transaction and empties once processed
        if (evt_take)
        begin
            evt_valid_next = 1'b1;
        end
        else if (process)
        begin
            evt_valid_next = 1'b0;
        end
        if (process)
        begin
            node_state_next = step_res.node_state;
            mgr_flag_next   = step_res.mgr_flag;
            app_flag_next   = step_res.app_flag;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            node_state_reg <= nmt_pkg::ST_OFFLINE;
            mgr_flag_reg   <= 1'b0;
            app_flag_reg   <= 1'b0;
        end
        else
        begin
            evt_valid_reg  <= evt_valid_next;
            res_valid_reg  <= res_valid_next;
            node_state_reg <= node_state_next;
            mgr_flag_reg   <= mgr_flag_next;
            app_flag_reg   <= app_flag_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_code_reg <= event_code;
        end
        if (process)
        begin
            res_reg <= step_res;
        end
    end

    assign res_valid           = res_valid_reg;
    assign new_state           = res_reg.node_state;
    assign status              = res_reg.status;
    assign manager_enabled     = res_reg.mgr_flag;
    assign application_entered = res_reg.app_flag;

endmodule

### rtl/nmt_step.sv
// Combinational next-state and handshake-flag logic for one event.
// Depends on nmt_pkg.
module nmt_step
(
    input  logic [3:0]          cur_state,
    input  logic                cur_mgr_flag,
    input  logic                cur_app_flag,
    input  logic [4:0]          event_code,
    output nmt_pkg::nmt_result_t result
);

    // reset requests shared by the communication states
    function automatic logic [3:0] common_reset(input logic [3:0] s, input logic [4:0] ev);
        logic [3:0] r;
        r = s;
        case (ev)
            nmt_pkg::EV_REQ_RST_APP: r = nmt_pkg::ST_RST_APP;
            nmt_pkg::EV_REQ_RST_COM: r = nmt_pkg::ST_RST_COM;
            nmt_pkg::EV_REQ_RST_CFG: r = nmt_pkg::ST_RST_CFG;
            nmt_pkg::EV_SW_RESET:    r = nmt_pkg::ST_INIT;
            default:                 r = s;
        endcase
        return r;
    endfunction

    // per-state transition table
    function automatic logic [3:0] table_next(input logic [3:0] s, input logic [4:0] ev);
        logic [3:0] r;
        r = s;
        case (s)
            nmt_pkg::ST_OFFLINE:
            begin
                if (ev inside {nmt_pkg::EV_SW_RESET, nmt_pkg::EV_START_UP,
                               nmt_pkg::EV_SWITCH_ON, nmt_pkg::EV_REQ_RST_APP,
                               nmt_pkg::EV_REQ_RST_COM, nmt_pkg::EV_REQ_RST_CFG})
                    r = nmt_pkg::ST_INIT;
            end
            nmt_pkg::ST_INIT:
            begin
                if (ev inside {nmt_pkg::EV_SWITCH_ON, nmt_pkg::EV_INT_RST_APP,
                               nmt_pkg::EV_REQ_RST_APP})
                    r = nmt_pkg::ST_RST_APP;
            end
            nmt_pkg::ST_RST_APP:
            begin
                if (ev inside {nmt_pkg::EV_INT_RST_COM, nmt_pkg::EV_REQ_RST_COM})
                    r = nmt_pkg::ST_RST_COM;
            end
            nmt_pkg::ST_RST_COM:
            begin
                if (ev inside {nmt_pkg::EV_INT_RST_CFG, nmt_pkg::EV_REQ_RST_CFG})
                    r = nmt_pkg::ST_RST_CFG;
            end
            nmt_pkg::ST_RST_CFG:
            begin
                if (ev inside {nmt_pkg::EV_INT_RST_APP, nmt_pkg::EV_SWITCH_ON})
                    r = nmt_pkg::ST_NOT_ACTIVE;
            end
            nmt_pkg::ST_NOT_ACTIVE:
            begin
                if (ev == nmt_pkg::EV_RECV_SOC)
                    r = nmt_pkg::ST_PREOP1;
                else if (ev == nmt_pkg::EV_RECV_SOA)
                    r = nmt_pkg::ST_BASIC_ETH;
                else
                    r = common_reset(s, ev);
            end
            nmt_pkg::ST_BASIC_ETH:
            begin
                if (ev == nmt_pkg::EV_RECV_SOC)
                    r = nmt_pkg::ST_PREOP1;
                else
                    r = common_reset(s, ev);
            end
            nmt_pkg::ST_PREOP1:
            begin
                if (ev inside {nmt_pkg::EV_RECV_SOC, nmt_pkg::EV_TO_PREOP2})
                    r = nmt_pkg::ST_PREOP2;
                else
                    r = common_reset(s, ev);
            end
            nmt_pkg::ST_PREOP2:
            begin
                if (ev == nmt_pkg::EV_ENTER_READY)
                    r = nmt_pkg::ST_READY;
                else if (ev inside {nmt_pkg::EV_TO_OPER, nmt_pkg::EV_START_NODE})
                    r = nmt_pkg::ST_OPER;
                else if (ev == nmt_pkg::EV_TO_PREOP1)
                    r = nmt_pkg::ST_PREOP1;
                else
                    r = common_reset(s, ev);
            end
            nmt_pkg::ST_READY:
            begin
                if (ev inside {nmt_pkg::EV_TO_OPER, nmt_pkg::EV_START_NODE})
                    r = nmt_pkg::ST_OPER;
                else if (ev == nmt_pkg::EV_TO_PREOP2)
                    r = nmt_pkg::ST_PREOP2;
                else if (ev == nmt_pkg::EV_TO_PREOP1)
                    r = nmt_pkg::ST_PREOP1;
                else if (ev == nmt_pkg::EV_STOP_NODE)
                    r = nmt_pkg::ST_STOPPED;
                else
                    r = common_reset(s, ev);
            end
            nmt_pkg::ST_OPER:
            begin
                if (ev == nmt_pkg::EV_STOP_NODE)
                    r = nmt_pkg::ST_STOPPED;
                else if (ev == nmt_pkg::EV_TO_PREOP2)
                    r = nmt_pkg::ST_PREOP2;
                else if (ev == nmt_pkg::EV_TO_PREOP1)
                    r = nmt_pkg::ST_PREOP1;
                else if (ev == nmt_pkg::EV_TO_READY)
                    r = nmt_pkg::ST_READY;
                else
                    r = common_reset(s, ev);
            end
            nmt_pkg::ST_STOPPED:
            begin
                if (ev inside {nmt_pkg::EV_START_NODE, nmt_pkg::EV_RESYNC})
                    r = nmt_pkg::ST_OPER;
                else if (ev == nmt_pkg::EV_TO_PREOP2)
                    r = nmt_pkg::ST_PREOP2;
                else if (ev == nmt_pkg::EV_TO_PREOP1)
                    r = nmt_pkg::ST_PREOP1;
                else if (ev == nmt_pkg::EV_TO_READY)
                    r = nmt_pkg::ST_READY;
                else
                    r = common_reset(s, ev);
            end
            // unreachable codes hold
            default: r = s;
        endcase
        return r;
    endfunction

    logic       mgr_set;
    logic       app_set;
    logic       handshake;
    logic [3:0] tbl_state;

    // sticky handshake flags are set before the transition is chosen
    assign mgr_set   = cur_mgr_flag | (event_code == nmt_pkg::EV_ENABLE_READY);
    assign app_set   = cur_app_flag | (event_code == nmt_pkg::EV_ENTER_READY);
    assign handshake = (cur_state == nmt_pkg::ST_PREOP2) &&
                       ((event_code == nmt_pkg::EV_ENABLE_READY) ||
                        (event_code == nmt_pkg::EV_ENTER_READY));
    assign tbl_state = table_next(cur_state, event_code);

    // handshake gate in preoperational 2, table otherwise
    always_comb
    begin
        result.node_state = cur_state;
        result.status     = 1'b1;
        result.mgr_flag   = mgr_set;
        result.app_flag   = app_set;
        if (handshake)
        begin
            if (mgr_set && app_set)
            begin
                result.node_state = nmt_pkg::ST_READY;
                result.status     = 1'b0;
            end
        end
        else if (tbl_state != cur_state)
        begin
            result.node_state = tbl_state;
            result.status     = 1'b0;
            // entering initialising or a reset state drops both flags
            if (tbl_state inside {[nmt_pkg::ST_INIT:nmt_pkg::ST_RST_CFG]})
            begin
                result.mgr_flag = 1'b0;
                result.app_flag = 1'b0;
            end
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for nmt_node_state_machine: event transactions in,
// one checked result transaction out per event, under random idling and stalls.
// Depends on nmt_pkg and the RTL of the block.
module tb;

    // event codes the block never moves on
    localparam logic [4:0] EV_UNUSED_LO = 5'd29;
    localparam logic [4:0] EV_UNUSED_HI = 5'd31;

    localparam int NUM_RANDOM     = 650;
    localparam int HOLD_AT        = 1750;
    localparam int HOLD_LEN       = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 10;

    // idle and stall percentages per idling phase
    localparam int SEND_IDLE_PCT [3] = '{24, 69, 0};
    localparam int RECV_STALL_PCT [3] = '{69, 24, 0};

    // directed walk: unused codes, full boot, handshake waiting and completion,
    // events without an entry, every communication state and the reset requests
    localparam logic [4:0] DIRECTED_EVENTS [25] = '{
        EV_UNUSED_HI, nmt_pkg::EV_ENABLE_READY, nmt_pkg::EV_START_UP,
        nmt_pkg::EV_SWITCH_ON, nmt_pkg::EV_INT_RST_COM,
        nmt_pkg::EV_INT_RST_CFG, nmt_pkg::EV_INT_RST_APP, nmt_pkg::EV_RECV_SOA,
        nmt_pkg::EV_RECV_SOC, nmt_pkg::EV_TO_PREOP2,
        nmt_pkg::EV_ENTER_READY, nmt_pkg::EV_ENTER_READY, nmt_pkg::EV_ENABLE_READY,
        nmt_pkg::EV_RECV_SOC, nmt_pkg::EV_START_NODE,
        nmt_pkg::EV_STOP_NODE, nmt_pkg::EV_RESYNC, nmt_pkg::EV_TO_READY,
        nmt_pkg::EV_TO_PREOP1, nmt_pkg::EV_SW_RESET,
        EV_UNUSED_LO, nmt_pkg::EV_REQ_RST_APP, nmt_pkg::EV_REQ_RST_COM,
        nmt_pkg::EV_REQ_RST_CFG, nmt_pkg::EV_SWITCH_ON
    };

    typedef struct packed {
        logic [4:0] code;
        logic       drain;
        logic [1:0] phase;
    } pending_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       evt_valid = 1'b0;
    logic       evt_stall;
    logic [4:0] event_code = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [3:0] new_state;
    logic       status;
    logic       manager_enabled;
    logic       application_entered;

    pending_event_t       pending_events[$];
    nmt_pkg::nmt_result_t expected_results[$];
    nmt_pkg::nmt_result_t node_model = '0;
    nmt_pkg::nmt_result_t plan_state = '0;

    int         n_sent = 0;
    int         n_recv = 0;
    int         n_errors = 0;
    int         n_moves = 0;
    int         n_held = 0;
    int         quiet_cycles = 0;
    int         hold_cnt = 0;
    logic       hold_done = 1'b0;
    logic [1:0] cur_phase = 2'd0;
    logic [15:0] states_seen = '0;

    nmt_node_state_machine dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .evt_valid           (evt_valid),
        .evt_stall           (evt_stall),
        .event_code          (event_code),
        .res_valid           (res_valid),
        .res_stall           (res_stall),
        .new_state           (new_state),
        .status              (status),
        .manager_enabled     (manager_enabled),
        .application_entered (application_entered)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // reset requests common to the communication states
    function automatic logic [3:0] reset_request(logic [3:0] s, logic [4:0] ev);
        case (ev)
            nmt_pkg::EV_REQ_RST_APP: return nmt_pkg::ST_RST_APP;
            nmt_pkg::EV_REQ_RST_COM: return nmt_pkg::ST_RST_COM;
            nmt_pkg::EV_REQ_RST_CFG: return nmt_pkg::ST_RST_CFG;
            nmt_pkg::EV_SW_RESET:    return nmt_pkg::ST_INIT;
            default:                 return s;
        endcase
    endfunction

    // per-state transition table
    function automatic logic [3:0] table_next(logic [3:0] s, logic [4:0] ev);
        case (s)
            nmt_pkg::ST_OFFLINE:
                if (ev == nmt_pkg::EV_SW_RESET || ev == nmt_pkg::EV_START_UP ||
                    ev == nmt_pkg::EV_SWITCH_ON || ev == nmt_pkg::EV_REQ_RST_APP ||
                    ev == nmt_pkg::EV_REQ_RST_COM || ev == nmt_pkg::EV_REQ_RST_CFG)
                    return nmt_pkg::ST_INIT;
            nmt_pkg::ST_INIT:
                if (ev == nmt_pkg::EV_SWITCH_ON || ev == nmt_pkg::EV_INT_RST_APP ||
                    ev == nmt_pkg::EV_REQ_RST_APP)
                    return nmt_pkg::ST_RST_APP;
            nmt_pkg::ST_RST_APP:
                if (ev == nmt_pkg::EV_INT_RST_COM || ev == nmt_pkg::EV_REQ_RST_COM)
                    return nmt_pkg::ST_RST_COM;
            nmt_pkg::ST_RST_COM:
                if (ev == nmt_pkg::EV_INT_RST_CFG || ev == nmt_pkg::EV_REQ_RST_CFG)
                    return nmt_pkg::ST_RST_CFG;
            nmt_pkg::ST_RST_CFG:
                if (ev == nmt_pkg::EV_INT_RST_APP || ev == nmt_pkg::EV_SWITCH_ON)
                    return nmt_pkg::ST_NOT_ACTIVE;
            nmt_pkg::ST_NOT_ACTIVE:
            begin
                if (ev == nmt_pkg::EV_RECV_SOC) return nmt_pkg::ST_PREOP1;
                if (ev == nmt_pkg::EV_RECV_SOA) return nmt_pkg::ST_BASIC_ETH;
                return reset_request(s, ev);
            end
            nmt_pkg::ST_BASIC_ETH:
            begin
                if (ev == nmt_pkg::EV_RECV_SOC) return nmt_pkg::ST_PREOP1;
                return reset_request(s, ev);
            end
            nmt_pkg::ST_PREOP1:
            begin
                if (ev == nmt_pkg::EV_RECV_SOC || ev == nmt_pkg::EV_TO_PREOP2)
                    return nmt_pkg::ST_PREOP2;
                return reset_request(s, ev);
            end
            nmt_pkg::ST_PREOP2:
            begin
                if (ev == nmt_pkg::EV_ENTER_READY) return nmt_pkg::ST_READY;
                if (ev == nmt_pkg::EV_TO_OPER || ev == nmt_pkg::EV_START_NODE)
                    return nmt_pkg::ST_OPER;
                if (ev == nmt_pkg::EV_TO_PREOP1) return nmt_pkg::ST_PREOP1;
                return reset_request(s, ev);
            end
            nmt_pkg::ST_READY:
            begin
                if (ev == nmt_pkg::EV_TO_OPER || ev == nmt_pkg::EV_START_NODE)
                    return nmt_pkg::ST_OPER;
                if (ev == nmt_pkg::EV_TO_PREOP2) return nmt_pkg::ST_PREOP2;
                if (ev == nmt_pkg::EV_TO_PREOP1) return nmt_pkg::ST_PREOP1;
                if (ev == nmt_pkg::EV_STOP_NODE) return nmt_pkg::ST_STOPPED;
                return reset_request(s, ev);
            end
            nmt_pkg::ST_OPER:
            begin
                if (ev == nmt_pkg::EV_STOP_NODE) return nmt_pkg::ST_STOPPED;
                if (ev == nmt_pkg::EV_TO_PREOP2) return nmt_pkg::ST_PREOP2;
                if (ev == nmt_pkg::EV_TO_PREOP1) return nmt_pkg::ST_PREOP1;
                if (ev == nmt_pkg::EV_TO_READY) return nmt_pkg::ST_READY;
                return reset_request(s, ev);
            end
            nmt_pkg::ST_STOPPED:
            begin
                if (ev == nmt_pkg::EV_START_NODE || ev == nmt_pkg::EV_RESYNC)
                    return nmt_pkg::ST_OPER;
                if (ev == nmt_pkg::EV_TO_PREOP2) return nmt_pkg::ST_PREOP2;
                if (ev == nmt_pkg::EV_TO_PREOP1) return nmt_pkg::ST_PREOP1;
                if (ev == nmt_pkg::EV_TO_READY) return nmt_pkg::ST_READY;
                return reset_request(s, ev);
            end
            default: ;
        endcase
        return s;
    endfunction

    // node state and handshake flags after one event
    function automatic nmt_pkg::nmt_result_t apply_event(nmt_pkg::nmt_result_t cur,
                                                         logic [4:0] ev);
        nmt_pkg::nmt_result_t r = cur;
        logic [3:0]           nxt;
        r.status = 1'b1;
        if (ev == nmt_pkg::EV_ENABLE_READY) r.mgr_flag = 1'b1;
        if (ev == nmt_pkg::EV_ENTER_READY) r.app_flag = 1'b1;
        if (cur.node_state == nmt_pkg::ST_PREOP2 &&
            (ev == nmt_pkg::EV_ENABLE_READY || ev == nmt_pkg::EV_ENTER_READY))
        begin
            // handshake: move only once both sides have asked
            if (r.mgr_flag && r.app_flag)
            begin
                r.node_state = nmt_pkg::ST_READY;
                r.status = 1'b0;
            end
        end
        else
        begin
            nxt = table_next(cur.node_state, ev);
            if (nxt != cur.node_state)
            begin
                r.node_state = nxt;
                r.status = 1'b0;
                if (nxt >= nmt_pkg::ST_INIT && nxt <= nmt_pkg::ST_RST_CFG)
                begin
                    r.mgr_flag = 1'b0;
                    r.app_flag = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // pick a random event, mostly one that moves the node onward
    function automatic logic [4:0] pick_event(nmt_pkg::nmt_result_t cur);
        logic [4:0]           onward[$];
        logic [4:0]           resets[$];
        nmt_pkg::nmt_result_t nxt;
        int                   r;
        for (int c = 0; c < 32; c++)
        begin
            nxt = apply_event(cur, 5'(c));
            if (nxt.status == 1'b0)
            begin
                if (cur.node_state >= nmt_pkg::ST_NOT_ACTIVE &&
                    nxt.node_state >= nmt_pkg::ST_INIT &&
                    nxt.node_state <= nmt_pkg::ST_RST_CFG)
                    resets.push_back(5'(c));
                else
                    onward.push_back(5'(c));
            end
        end
        r = $urandom_range(99);
        if (r < 60 && onward.size() > 0) return onward[$urandom_range(onward.size() - 1)];
        if (r < 72 && resets.size() > 0) return resets[$urandom_range(resets.size() - 1)];
        if (r < 87)
            return $urandom_range(1) ? nmt_pkg::EV_ENABLE_READY : nmt_pkg::EV_ENTER_READY;
        return 5'($urandom_range(31));
    endfunction

    task automatic queue_event(logic [4:0] code, logic [1:0] phase);
        pending_events.push_back('{code: code, drain: 1'b0, phase: phase});
        plan_state = apply_event(plan_state, code);
    endtask

    task automatic queue_drain(logic [1:0] phase);
        pending_events.push_back('{code: '0, drain: 1'b1, phase: phase});
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // event driver: predicts each accepted transaction, then offers the next
    always @(posedge clk)
    begin
        nmt_pkg::nmt_result_t want;
        int                   sent_now;
        logic                 offer;
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
        end
        else
        begin
            sent_now = n_sent;
            if (evt_valid && !evt_stall)
            begin
                want = apply_event(node_model, event_code);
                node_model = want;
                expected_results.push_back(want);
                sent_now = n_sent + 1;
                n_sent <= sent_now;
            end
            if (!evt_valid || !evt_stall)
            begin
                // a drain marker holds the sender until every result is back
                while (pending_events.size() > 0 && pending_events[0].drain &&
                       n_recv == sent_now)
                    void'(pending_events.pop_front());
                offer = pending_events.size() > 0 && !pending_events[0].drain &&
                        $urandom_range(99) >= SEND_IDLE_PCT[pending_events[0].phase];
                if (offer)
                begin
                    event_code <= pending_events[0].code;
                    cur_phase <= pending_events[0].phase;
                    void'(pending_events.pop_front());
                end
                evt_valid <= offer;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin
        nmt_pkg::nmt_result_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                n_recv <= n_recv + 1;
                states_seen[new_state] = 1'b1;
                if (status) n_held++;
                else n_moves++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, state %0d status %0d",
                             $time, new_state, status);
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("new_state", want.node_state, new_state);
                    check_field("status", want.status, status);
                    check_field("manager_enabled", want.mgr_flag, manager_enabled);
                    check_field("application_entered", want.app_flag, application_entered);
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                res_stall <= 1'b1;
            end
            else if (!hold_done && n_recv >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_cnt <= HOLD_LEN;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= $urandom_range(99) < RECV_STALL_PCT[cur_phase];
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: errors");
                $finish;
            end
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin
        foreach (DIRECTED_EVENTS[i])
            queue_event(DIRECTED_EVENTS[i], 2'd0);
        for (int ph = 0; ph < 3; ph++)
        begin
            queue_drain(2'(ph));
            for (int i = 0; i < NUM_RANDOM; i++)
                queue_event(pick_event(plan_state), 2'(ph));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() != 0 || evt_valid || n_recv != n_sent)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            n_errors++;
        end
        $display("summary: %0d events checked, %0d moved, %0d held, %0d states visited",
                 n_recv, n_moves, n_held, $countones(states_seen));
        $display("summary: three idle/stall phases, one long result hold-off, %0d errors",
                 n_errors);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
